FILE: rtl/slotted_page_manager_unit_defines.svh
// Assertion macros for the RTL of the slotted page manager, used by spm_dpath.
`ifndef SLOTTED_PAGE_MANAGER_UNIT_DEFINES_SVH
`define SLOTTED_PAGE_MANAGER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/spm_pkg.sv
package spm_pkg;

  // Page geometry.
  localparam int PAGE_BYTES   = 4096;
  localparam int HEADER_BYTES = 8;
  localparam int SLOT_BYTES   = 4;
  localparam int MAX_SLOTS    = 1024;

  // Field widths fixed by the interface.
  localparam int OP_W  = 2;
  localparam int LEN_W = 12;
  localparam int IDX_W = 10;

  // Internal widths derived from the geometry.
  localparam int FP_W    = $clog2(PAGE_BYTES + 1);
  localparam int CNT_W   = $clog2(MAX_SLOTS + 1);
  localparam int SLOT_AW = $clog2(MAX_SLOTS);
  localparam int SUM_W   = $clog2(PAGE_BYTES + HEADER_BYTES + MAX_SLOTS * SLOT_BYTES
                                  + (1 << LEN_W) + SLOT_BYTES + (1 << IDX_W) + 1);

  // Operation codes.
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_GET    = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [LEN_W-1:0] tuple_length;
    logic [IDX_W-1:0] slot_index;
  } spm_in_t;

  typedef struct packed {
    logic             ok;
    logic [IDX_W-1:0] slot_number;
    logic [LEN_W-1:0] byte_offset;
    logic [LEN_W-1:0] byte_length;
  } spm_out_t;

  // One directory entry as stored in the slot memory.
  typedef struct packed {
    logic [LEN_W-1:0] offset;
    logic [LEN_W-1:0] length;
  } spm_entry_t;

  typedef enum logic [0:0] {
    S_IDLE,
    S_EXEC
  } spm_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic complete;
  } spm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } spm_sts_t;

endpackage

FILE: rtl/slotted_page_manager_unit.sv
// Slot directory of one slotted database page. Each item is an insert, a get or a
// delete, and each gives exactly one result item. On acceptance the slot memory is
// read at the given slot into a register; in the EXEC state that follows the result
// is evaluated, and once the output register is free the free pointer, slot count and
// slot memory are updated and the result is loaded into the output register. A new
// item is accepted only after the previous one has completed, while its result may
// still wait for out_ready; a full output register holds the block in EXEC. Items do not
// overlap, as each makes one read-then-write access to the slot memory. The slot memory
// needs no clearing after reset, so items are accepted from the first cycle.
module slotted_page_manager_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  spm_pkg::spm_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output spm_pkg::spm_out_t out_data
);

  spm_pkg::spm_cmd_t cmd;
  spm_pkg::spm_sts_t sts;

  spm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  spm_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

FILE: rtl/spm_ctrl.sv
module spm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output spm_pkg::spm_cmd_t cmd,
  input  spm_pkg::spm_sts_t sts
);

  spm_pkg::spm_state_t state_r;
  spm_pkg::spm_state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spm_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state: an accepted item reads the slot memory, then waits in EXEC
  // until the output register can take its result.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      spm_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = spm_pkg::S_EXEC;
        end
      end
      spm_pkg::S_EXEC: begin
        if (sts.out_free) begin
          state_nxt = spm_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = spm_pkg::S_IDLE;
      end
    endcase
  end

  // Outputs: handshake and datapath commands.
  always_comb begin
    in_ready     = 1'b0;
    cmd.accept   = 1'b0;
    cmd.complete = 1'b0;
    unique case (state_r)
      spm_pkg::S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      spm_pkg::S_EXEC: begin
        cmd.complete = sts.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

FILE: rtl/spm_dpath.sv
`include "slotted_page_manager_unit_defines.svh"

module spm_dpath (
  input  logic              clk,
  input  logic              rst_n,
  input  spm_pkg::spm_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output spm_pkg::spm_out_t out_data,
  input  spm_pkg::spm_cmd_t cmd,
  output spm_pkg::spm_sts_t sts
);

  // Slot directory memory, one entry per slot.
  spm_pkg::spm_entry_t mem [spm_pkg::MAX_SLOTS];

  // Latched item and the entry read for it.
  logic [spm_pkg::OP_W-1:0]  op_r;
  logic [spm_pkg::LEN_W-1:0] len_r;
  logic [spm_pkg::IDX_W-1:0] idx_r;
  spm_pkg::spm_entry_t       rd_r;

  // Page state.
  logic [spm_pkg::FP_W-1:0]  fp_r;
  logic [spm_pkg::FP_W-1:0]  fp_nxt;
  logic [spm_pkg::CNT_W-1:0] count_r;
  logic [spm_pkg::CNT_W-1:0] count_nxt;

  // Output register.
  logic              out_valid_r;
  spm_pkg::spm_out_t out_r;
  spm_pkg::spm_out_t out_nxt;

  // Evaluation terms.
  logic [spm_pkg::SUM_W-1:0] used_bytes;
  logic [spm_pkg::SUM_W-1:0] need_top;
  logic [spm_pkg::FP_W-1:0]  fp_ins;
  logic                      dir_full;
  logic                      ins_ok;
  logic                      idx_ok;
  logic                      rd_ok;
  logic                      mem_we;
  logic [spm_pkg::SLOT_AW-1:0] mem_waddr;
  spm_pkg::spm_entry_t       mem_wdata;

  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign out_data     = out_r;

  // Latch the item and read its slot entry on acceptance.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r  <= in_data.op;
      len_r <= in_data.tuple_length;
      idx_r <= in_data.slot_index;
      rd_r  <= mem[spm_pkg::SLOT_AW'(in_data.slot_index)];
    end
  end

  // Insert fits when the pointer stays above header, directory and new entry.
  assign used_bytes = spm_pkg::SUM_W'(spm_pkg::HEADER_BYTES)
                    + spm_pkg::SUM_W'(count_r) * spm_pkg::SUM_W'(spm_pkg::SLOT_BYTES);
  assign need_top   = used_bytes + spm_pkg::SUM_W'(len_r)
                    + spm_pkg::SUM_W'(spm_pkg::SLOT_BYTES);
  assign dir_full   = count_r >= spm_pkg::CNT_W'(spm_pkg::MAX_SLOTS);
  assign ins_ok     = !dir_full && (spm_pkg::SUM_W'(fp_r) >= need_top);
  assign fp_ins     = fp_r - spm_pkg::FP_W'(len_r);

  // Get and delete need a live slot below the count.
  assign idx_ok = spm_pkg::SUM_W'(idx_r) < spm_pkg::SUM_W'(count_r);
  assign rd_ok  = idx_ok && (rd_r.length != '0);

  // Result, state update and memory write for the item in flight.
  always_comb begin
    out_nxt   = '0;
    fp_nxt    = fp_r;
    count_nxt = count_r;
    mem_we    = 1'b0;
    mem_waddr = spm_pkg::SLOT_AW'(idx_r);
    mem_wdata = '0;
    unique case (op_r)
      spm_pkg::OP_INSERT: begin
        if (ins_ok) begin
          out_nxt.ok          = 1'b1;
          out_nxt.slot_number = spm_pkg::IDX_W'(count_r);
          out_nxt.byte_offset = spm_pkg::LEN_W'(fp_ins);
          out_nxt.byte_length = len_r;
          fp_nxt              = fp_ins;
          count_nxt           = count_r + 1'b1;
          mem_we              = 1'b1;
          mem_waddr           = spm_pkg::SLOT_AW'(count_r);
          mem_wdata.offset    = spm_pkg::LEN_W'(fp_ins);
          mem_wdata.length    = len_r;
        end
      end
      spm_pkg::OP_GET: begin
        out_nxt.slot_number = idx_r;
        if (rd_ok) begin
          out_nxt.ok          = 1'b1;
          out_nxt.byte_offset = rd_r.offset;
          out_nxt.byte_length = rd_r.length;
        end
      end
      spm_pkg::OP_DELETE: begin
        out_nxt.slot_number = idx_r;
        if (rd_ok) begin
          out_nxt.ok = 1'b1;
          mem_we     = 1'b1;
        end
      end
      default: begin
        out_nxt = '0;
      end
    endcase
  end

  // Slot memory write port.
  always_ff @(posedge clk) begin
    if (cmd.complete && mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // Page state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fp_r    <= spm_pkg::FP_W'(spm_pkg::PAGE_BYTES);
      count_r <= '0;
    end else if (cmd.complete) begin
      fp_r    <= fp_nxt;
      count_r <= count_nxt;
    end
  end

  // Output register: loaded on completion, emptied when taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.complete) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.complete) begin
      out_r <= out_nxt;
    end
  end

  `SPM_ASSERT_SAME(a_no_overwrite, cmd.complete, sts.out_free, "result overwrote a waiting item")
  `SPM_ASSERT_SAME(a_count_limit, 1'b1, count_r <= spm_pkg::CNT_W'(spm_pkg::MAX_SLOTS), "slot count above limit")
  `SPM_ASSERT_SAME(a_fp_above_dir, 1'b1, spm_pkg::SUM_W'(fp_r) >= used_bytes, "free pointer ran into the directory")
  `SPM_ASSERT_NEXT(a_insert_count, cmd.complete && (op_r == spm_pkg::OP_INSERT) && ins_ok, count_r == $past(count_r) + 1'b1, "insert did not advance the slot count")

endmodule
